[hw/rtl/sli_pkg.sv]
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the segment/line intersection block
// Word layouts, derived widths and the fixed-point limits used across files.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

    localparam int CW   = 32;           // coordinate width
    localparam int FRAC = 16;           // fraction bits
    localparam int DIFW = CW + 1;       // coordinate difference
    localparam int PW   = 2 * DIFW;     // product of two differences
    localparam int SW   = PW + 1;       // sum of two products
    localparam int LOW  = DIFW;         // low slice of a wide multiplicand
    localparam int HIW  = SW - LOW;     // high slice of a wide multiplicand
    localparam int NW   = DIFW + SW;    // dividend width
    localparam int EW   = NW + 2;       // base plus signed quotient

    // |dx| * 100 < 2^FRAC and |dx| * 1000 < 2^FRAC, as plain bounds
    localparam int VERT_LIM = ((2 ** FRAC) - 1) / 100;
    localparam int NEAR_LIM = ((2 ** FRAC) - 1) / 1000;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [CW-1:0] a_start_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_end_y;
    } seg_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_y;
    } res_t;

    // classified job handed from front to back: cross = base + floor(m * nop / den)
    typedef struct packed {
        logic                   hit;
        logic signed [DIFW-1:0] mx;
        logic signed [DIFW-1:0] my;
        logic signed [SW-1:0]   nop;
        logic signed [SW-1:0]   den;
        logic signed [CW-1:0]   base_x;
        logic signed [CW-1:0]   base_y;
    } job_t;

endpackage

`default_nettype wire

[hw/rtl/sli_front.sv]
// ----------------------------------------------------------------------------
// sli_front: accept and classify
// Three register stages: differences, products, sums; then the side tests and
// the choice of divider operands for the hit case.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          seg_valid,
    output logic               seg_ready,
    input  wire sli_pkg::seg_t seg,
    output logic               job_valid,
    input  wire logic          job_ready,
    output sli_pkg::job_t      job
);

    localparam int DIFW = sli_pkg::DIFW;
    localparam int PW   = sli_pkg::PW;
    localparam int SW   = sli_pkg::SW;
    localparam int CW   = sli_pkg::CW;
    localparam logic signed [DIFW-1:0] VLIM = DIFW'(sli_pkg::VERT_LIM);
    localparam logic signed [DIFW-1:0] NLIM = DIFW'(sli_pkg::NEAR_LIM);

    function automatic logic signed [DIFW-1:0] dif(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [DIFW-1:0] ae;
        logic signed [DIFW-1:0] be;
        ae = {a[CW-1], a};
        be = {b[CW-1], b};
        return ae - be;
    endfunction

    function automatic logic signed [SW-1:0] sx(input logic signed [PW-1:0] p);
        return {p[PW-1], p};
    endfunction

    function automatic logic signed [SW-1:0] dx(input logic signed [DIFW-1:0] d);
        return {{(SW-DIFW){d[DIFW-1]}}, d};
    endfunction

    logic en;
    logic f1_valid_reg, f2_valid_reg, f3_valid_reg;

    // stage 1: differences
    logic signed [DIFW-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, ex_reg, ey_reg;
    logic signed [DIFW-1:0] fx_reg, fy_reg, hy_reg, gx_reg;
    logic signed [CW-1:0]   ax2_1_reg, ay2_1_reg, bx2_1_reg, by2_1_reg;
    logic                   box_1_reg;
    logic                   box_miss;

    // stage 2: products
    logic signed [PW-1:0]   p_reg [0:9];
    logic signed [DIFW-1:0] dxa2_reg, dya2_reg, dxb2_reg, dyb2_reg, ex2_reg;
    logic signed [CW-1:0]   ax2_2_reg, ay2_2_reg, bx2_2_reg, by2_2_reg;
    logic                   box_2_reg, va_2_reg, vb_2_reg, near_2_reg;

    // stage 3: sums
    logic signed [SW-1:0]   n_reg, s7_reg, t1_reg, t2_reg, den_reg;
    logic signed [DIFW-1:0] dxa3_reg, dya3_reg, dxb3_reg, dyb3_reg, ex3_reg;
    logic signed [CW-1:0]   ax2_3_reg, ay2_3_reg, bx2_3_reg, by2_3_reg;
    logic                   box_3_reg, va_3_reg, vb_3_reg, near_3_reg;

    assign en        = !(f3_valid_reg && !job_ready);
    assign seg_ready = en;
    assign job_valid = f3_valid_reg;

    always_comb
    begin
        box_miss = (seg.a_start_x < seg.b_start_x && seg.a_start_x < seg.b_end_x &&
                    seg.a_end_x < seg.b_start_x && seg.a_end_x < seg.b_end_x) ||
                   (seg.a_start_y < seg.b_start_y && seg.a_start_y < seg.b_end_y &&
                    seg.a_end_y < seg.b_start_y && seg.a_end_y < seg.b_end_y) ||
                   (seg.b_start_x < seg.a_start_x && seg.b_start_x < seg.a_end_x &&
                    seg.b_end_x < seg.a_start_x && seg.b_end_x < seg.a_end_x) ||
                   (seg.b_start_y < seg.a_start_y && seg.b_start_y < seg.a_end_y &&
                    seg.b_end_y < seg.a_start_y && seg.b_end_y < seg.a_end_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= seg_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxa_reg   <= dif(seg.a_end_x, seg.a_start_x);
            dya_reg   <= dif(seg.a_end_y, seg.a_start_y);
            dxb_reg   <= dif(seg.b_end_x, seg.b_start_x);
            dyb_reg   <= dif(seg.b_end_y, seg.b_start_y);
            ex_reg    <= dif(seg.b_end_x, seg.a_end_x);
            ey_reg    <= dif(seg.b_end_y, seg.a_end_y);
            fx_reg    <= dif(seg.b_end_x, seg.a_start_x);
            fy_reg    <= dif(seg.a_start_y, seg.b_end_y);
            hy_reg    <= dif(seg.b_start_y, seg.a_end_y);
            gx_reg    <= dif(seg.a_end_x, seg.b_start_x);
            ax2_1_reg <= seg.a_end_x;
            ay2_1_reg <= seg.a_end_y;
            bx2_1_reg <= seg.b_end_x;
            by2_1_reg <= seg.b_end_y;
            box_1_reg <= box_miss;

            p_reg[0]   <= ex_reg * dyb_reg;
            p_reg[1]   <= ey_reg * dxb_reg;
            p_reg[2]   <= fx_reg * dyb_reg;
            p_reg[3]   <= fy_reg * dxb_reg;
            p_reg[4]   <= ey_reg * dxa_reg;
            p_reg[5]   <= ex_reg * dya_reg;
            p_reg[6]   <= hy_reg * dxa_reg;
            p_reg[7]   <= gx_reg * dya_reg;
            p_reg[8]   <= dxa_reg * dyb_reg;
            p_reg[9]   <= dya_reg * dxb_reg;
            dxa2_reg   <= dxa_reg;
            dya2_reg   <= dya_reg;
            dxb2_reg   <= dxb_reg;
            dyb2_reg   <= dyb_reg;
            ex2_reg    <= ex_reg;
            ax2_2_reg  <= ax2_1_reg;
            ay2_2_reg  <= ay2_1_reg;
            bx2_2_reg  <= bx2_1_reg;
            by2_2_reg  <= by2_1_reg;
            box_2_reg  <= box_1_reg;
            va_2_reg   <= (dxa_reg >= -VLIM) && (dxa_reg <= VLIM);
            vb_2_reg   <= (dxb_reg >= -VLIM) && (dxb_reg <= VLIM);
            near_2_reg <= (ex_reg >= -NLIM) && (ex_reg <= NLIM);

            n_reg      <= sx(p_reg[0]) - sx(p_reg[1]);
            s7_reg     <= sx(p_reg[2]) + sx(p_reg[3]);
            t1_reg     <= sx(p_reg[4]) - sx(p_reg[5]);
            t2_reg     <= sx(p_reg[6]) + sx(p_reg[7]);
            den_reg    <= sx(p_reg[8]) - sx(p_reg[9]);
            dxa3_reg   <= dxa2_reg;
            dya3_reg   <= dya2_reg;
            dxb3_reg   <= dxb2_reg;
            dyb3_reg   <= dyb2_reg;
            ex3_reg    <= ex2_reg;
            ax2_3_reg  <= ax2_2_reg;
            ay2_3_reg  <= ay2_2_reg;
            bx2_3_reg  <= bx2_2_reg;
            by2_3_reg  <= by2_2_reg;
            box_3_reg  <= box_2_reg;
            va_3_reg   <= va_2_reg;
            vb_3_reg   <= vb_2_reg;
            near_3_reg <= near_2_reg;
        end
    end

    logic z6, z7, z1, z2, side_miss, line_miss;

    always_comb
    begin
        z6 = (n_reg == '0);
        z7 = (s7_reg == '0);
        z1 = (t1_reg == '0);
        z2 = (t2_reg == '0);
        // A's endpoints strictly on one side of B's line
        side_miss = !z6 && !z7 && (n_reg[SW-1] == s7_reg[SW-1]);
        if (z6 || !z7)
            side_miss = side_miss || (!z1 && !z2 && (t1_reg[SW-1] == t2_reg[SW-1]));
        else
            side_miss = side_miss || box_3_reg;

        job.mx     = '0;
        job.my     = '0;
        job.nop    = '0;
        job.den    = SW'(1);
        job.base_x = bx2_3_reg;
        job.base_y = by2_3_reg;
        line_miss  = 1'b0;
        unique case ({va_3_reg, vb_3_reg})
            2'b00:
            begin
                job.mx     = dxa3_reg;
                job.my     = dya3_reg;
                job.nop    = n_reg;
                job.den    = den_reg;
                job.base_x = ax2_3_reg;
                job.base_y = ay2_3_reg;
                line_miss  = (den_reg == '0);
            end
            2'b10:
            begin
                job.my     = -dyb3_reg;
                job.nop    = -dx(ex3_reg);
                job.den    = -dx(dxb3_reg);
                job.base_x = ax2_3_reg;
                job.base_y = by2_3_reg;
            end
            2'b01:
            begin
                job.my     = -dya3_reg;
                job.nop    = dx(ex3_reg);
                job.den    = -dx(dxa3_reg);
                job.base_x = bx2_3_reg;
                job.base_y = ay2_3_reg;
            end
            2'b11:
            begin
                line_miss = !near_3_reg;
            end
            default:
            begin
                line_miss = 1'b1;
            end
        endcase

        job.hit = !side_miss && !line_miss;
        // keep the divider away from a zero divisor on a miss
        if (!job.hit)
            job.den = SW'(1);
    end

endmodule

`default_nettype wire

[hw/rtl/sli_queue.sv]
// ----------------------------------------------------------------------------
// sli_queue: job queue between front and back
// Small flop FIFO; each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire sli_pkg::job_t wr_job,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output sli_pkg::job_t      rd_job
);

    localparam int QAW    = sli_pkg::QAW;
    localparam int QDEPTH = sli_pkg::QDEPTH;

    sli_pkg::job_t  mem [0:QDEPTH-1];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           push, pop;

    assign wr_ready = (cnt_reg != QAW'(0) + (QAW+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_job;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a write");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg - rp_reg) == cnt_reg[QAW-1:0])
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[hw/rtl/sli_back.sv]
// ----------------------------------------------------------------------------
// sli_back: crossing point evaluation
// Split multiply, magnitude, restoring divide one quotient bit per stage for
// x and y on a shared divisor, floor correction, base add and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire sli_pkg::job_t job,
    output logic               res_valid,
    input  wire logic          res_ready,
    output sli_pkg::res_t      res
);

    localparam int CW  = sli_pkg::CW;
    localparam int PW  = sli_pkg::PW;
    localparam int SW  = sli_pkg::SW;
    localparam int LOW = sli_pkg::LOW;
    localparam int HIW = sli_pkg::HIW;
    localparam int NW  = sli_pkg::NW;
    localparam int EW  = sli_pkg::EW;
    localparam int NQ  = NW;

    logic en;
    assign en        = !res_valid || res_ready;
    assign job_ready = en;

    // stage b1: partial products
    logic                 b1_valid_reg, b1_hit_reg;
    logic signed [PW-1:0] b1_xl_reg, b1_xh_reg, b1_yl_reg, b1_yh_reg;
    logic signed [SW-1:0] b1_den_reg;
    logic signed [CW-1:0] b1_bx_reg, b1_by_reg;

    // stage b2: full dividends
    logic                 b2_valid_reg, b2_hit_reg;
    logic signed [NW-1:0] b2_nx_reg, b2_ny_reg;
    logic signed [SW-1:0] b2_den_reg;
    logic signed [CW-1:0] b2_bx_reg, b2_by_reg;

    // divider pipeline; index 0 is loaded with magnitudes
    logic              dv_valid_reg [0:NQ];
    logic              dv_hit_reg   [0:NQ];
    logic              dv_negx_reg  [0:NQ];
    logic              dv_negy_reg  [0:NQ];
    logic [SW-1:0]     dv_d_reg     [0:NQ];
    logic [SW-1:0]     dv_rx_reg    [0:NQ];
    logic [SW-1:0]     dv_ry_reg    [0:NQ];
    logic [NW-1:0]     dv_qx_reg    [0:NQ];
    logic [NW-1:0]     dv_qy_reg    [0:NQ];
    logic [CW-1:0]     dv_bx_reg    [0:NQ];
    logic [CW-1:0]     dv_by_reg    [0:NQ];

    // stage e1: signed floor quotients
    logic                 e1_valid_reg, e1_hit_reg;
    logic signed [NW:0]   e1_qx_reg, e1_qy_reg;
    logic signed [CW-1:0] e1_bx_reg, e1_by_reg;

    // stage e2: output word
    logic          e2_valid_reg;
    sli_pkg::res_t e2_res_reg;

    assign res_valid = e2_valid_reg;
    assign res       = e2_res_reg;

    function automatic logic signed [NW-1:0] widen(input logic signed [PW-1:0] hi,
                                                   input logic signed [PW-1:0] lo);
        logic signed [NW-1:0] h;
        logic signed [NW-1:0] l;
        h = {{(NW-PW){hi[PW-1]}}, hi};
        l = {{(NW-PW){lo[PW-1]}}, lo};
        return (h <<< LOW) + l;
    endfunction

    function automatic logic [NW-1:0] mag_n(input logic signed [NW-1:0] v);
        return v[NW-1] ? NW'(-v) : NW'(v);
    endfunction

    function automatic logic signed [NW:0] fl(input logic neg, input logic [NW-1:0] q,
                                              input logic [SW-1:0] r);
        logic signed [NW:0] qe;
        qe = {1'b0, q};
        if (neg)
            return -qe - ((r != '0) ? (NW+1)'(1) : (NW+1)'(0));
        return qe;
    endfunction

    function automatic logic [CW-1:0] sat(input logic signed [CW-1:0] b,
                                          input logic signed [NW:0] q);
        logic signed [EW-1:0] s;
        logic [EW-CW:0]       top;
        s   = {{(EW-CW){b[CW-1]}}, b} + {q[NW], q};
        top = s[EW-1:CW-1];
        if ((&top) || !(|top))
            return s[CW-1:0];
        return s[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg    <= 1'b0;
            b2_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
            e1_valid_reg    <= 1'b0;
            e2_valid_reg    <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg    <= job_valid;
            b2_valid_reg    <= b1_valid_reg;
            dv_valid_reg[0] <= b2_valid_reg;
            e1_valid_reg    <= dv_valid_reg[NQ];
            e2_valid_reg    <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_hit_reg <= job.hit;
            b1_xl_reg  <= job.mx * $signed({1'b0, job.nop[LOW-1:0]});
            b1_xh_reg  <= job.mx * $signed(job.nop[SW-1:SW-HIW]);
            b1_yl_reg  <= job.my * $signed({1'b0, job.nop[LOW-1:0]});
            b1_yh_reg  <= job.my * $signed(job.nop[SW-1:SW-HIW]);
            b1_den_reg <= job.den;
            b1_bx_reg  <= job.base_x;
            b1_by_reg  <= job.base_y;

            b2_hit_reg <= b1_hit_reg;
            b2_nx_reg  <= widen(b1_xh_reg, b1_xl_reg);
            b2_ny_reg  <= widen(b1_yh_reg, b1_yl_reg);
            b2_den_reg <= b1_den_reg;
            b2_bx_reg  <= b1_bx_reg;
            b2_by_reg  <= b1_by_reg;

            dv_hit_reg[0]  <= b2_hit_reg;
            dv_negx_reg[0] <= b2_nx_reg[NW-1] ^ b2_den_reg[SW-1];
            dv_negy_reg[0] <= b2_ny_reg[NW-1] ^ b2_den_reg[SW-1];
            dv_d_reg[0]    <= b2_den_reg[SW-1] ? SW'(-b2_den_reg) : SW'(b2_den_reg);
            dv_rx_reg[0]   <= '0;
            dv_ry_reg[0]   <= '0;
            dv_qx_reg[0]   <= mag_n(b2_nx_reg);
            dv_qy_reg[0]   <= mag_n(b2_ny_reg);
            dv_bx_reg[0]   <= b2_bx_reg;
            dv_by_reg[0]   <= b2_by_reg;

            e1_hit_reg <= dv_hit_reg[NQ];
            e1_qx_reg  <= fl(dv_negx_reg[NQ], dv_qx_reg[NQ], dv_rx_reg[NQ]);
            e1_qy_reg  <= fl(dv_negy_reg[NQ], dv_qy_reg[NQ], dv_ry_reg[NQ]);
            e1_bx_reg  <= dv_bx_reg[NQ];
            e1_by_reg  <= dv_by_reg[NQ];

            // drop the point on a miss
            e2_res_reg.hit     <= e1_hit_reg;
            e2_res_reg.cross_x <= e1_hit_reg ? sat(e1_bx_reg, e1_qx_reg) : '0;
            e2_res_reg.cross_y <= e1_hit_reg ? sat(e1_by_reg, e1_qy_reg) : '0;
        end
    end

    // one quotient bit per stage: dividend shifts out the top, quotient in the bottom
    for (genvar k = 0; k < NQ; k++)
    begin : g_div
        logic [SW:0] shx, shy, dfx, dfy;

        always_comb
        begin
            shx = {dv_rx_reg[k], dv_qx_reg[k][NW-1]};
            shy = {dv_ry_reg[k], dv_qy_reg[k][NW-1]};
            dfx = shx - {1'b0, dv_d_reg[k]};
            dfy = shy - {1'b0, dv_d_reg[k]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_hit_reg[k+1]  <= dv_hit_reg[k];
                dv_negx_reg[k+1] <= dv_negx_reg[k];
                dv_negy_reg[k+1] <= dv_negy_reg[k];
                dv_d_reg[k+1]    <= dv_d_reg[k];
                dv_bx_reg[k+1]   <= dv_bx_reg[k];
                dv_by_reg[k+1]   <= dv_by_reg[k];
                if (!dfx[SW])
                begin
                    dv_rx_reg[k+1] <= dfx[SW-1:0];
                    dv_qx_reg[k+1] <= {dv_qx_reg[k][NW-2:0], 1'b1};
                end
                else
                begin
                    dv_rx_reg[k+1] <= shx[SW-1:0];
                    dv_qx_reg[k+1] <= {dv_qx_reg[k][NW-2:0], 1'b0};
                end
                if (!dfy[SW])
                begin
                    dv_ry_reg[k+1] <= dfy[SW-1:0];
                    dv_qy_reg[k+1] <= {dv_qy_reg[k][NW-2:0], 1'b1};
                end
                else
                begin
                    dv_ry_reg[k+1] <= shy[SW-1:0];
                    dv_qy_reg[k+1] <= {dv_qy_reg[k][NW-2:0], 1'b0};
                end
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/segment_line_intersection.sv]
// ----------------------------------------------------------------------------
// segment_line_intersection: segment versus wall crossing test
// Top level: classifying front, job queue, divide-and-saturate back.
// ----------------------------------------------------------------------------
// Takes one segment pair per ready clock, returns one result word per pair, in
// order: a hit flag and the saturated Q16.16 crossing point (zero on a miss).
// Throughput is one word per cycle whenever the result side keeps taking.
// On its way from acceptance to result valid a pair passes three front stages
// (differences, 33x33 products, sums), the first loaded at acceptance, a
// registered write into the four-entry job queue, and 105 back stages, set
// mostly by the restoring divider that resolves one quotient bit per stage
// over a 100-bit dividend.
// Both sides hold their words under backpressure; the queue lets the front
// keep accepting while the back is stalled, until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_line_intersection (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          seg_valid,
    output logic               seg_ready,
    input  wire sli_pkg::seg_t seg,
    output logic               res_valid,
    input  wire logic          res_ready,
    output sli_pkg::res_t      res
);

    logic          fj_valid, fj_ready, bj_valid, bj_ready;
    sli_pkg::job_t fj, bj;

    sli_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fj)
    );

    sli_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_job   (fj),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_job   (bj)
    );

    sli_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire
